FILE: hdl/mbsp_pkg.sv
// Shared types and constants for the MIDI byte stream parser.
`timescale 1ns / 1ps

package mbsp_pkg;

	localparam int SYSEX_DEPTH_DEF = 64;

	localparam logic [7:0] ST_SYSEX   = 8'hF0;
	localparam logic [7:0] ST_QFRAME  = 8'hF1;
	localparam logic [7:0] ST_SONGPOS = 8'hF2;
	localparam logic [7:0] ST_EOX     = 8'hF7;
	localparam logic [7:0] ST_START   = 8'hFA;
	localparam logic [7:0] ST_CONT    = 8'hFB;
	localparam logic [7:0] ST_STOP    = 8'hFC;
	localparam logic [3:0] ST_SYSTEM  = 4'hF;

	localparam logic [2:0] CH_PROG      = 3'd4;
	localparam logic [2:0] CH_CHANPRESS = 3'd5;

	localparam logic [3:0] KIND_SYSEX   = 4'd7;
	localparam logic [3:0] KIND_QFRAME  = 4'd8;
	localparam logic [3:0] KIND_SONGPOS = 4'd9;
	localparam logic [3:0] KIND_START   = 4'd10;
	localparam logic [3:0] KIND_CONT    = 4'd11;
	localparam logic [3:0] KIND_STOP    = 4'd12;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_MSG,
		MODE_SYSEX
	} mbsp_mode_t;

	typedef enum logic [1:0] {
		CS_RUN,
		CS_DUMP_RD,
		CS_DUMP_WR
	} mbsp_state_t;

	typedef struct packed {
		logic take;
		logic load_sx;
		logic step;
		logic finish;
	} mbsp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic dump_req;
		logic dump_last;
	} mbsp_stat_t;

endpackage

FILE: hdl/mbsp_if.sv
// Request channels: received byte in, parsed message out.
`timescale 1ns / 1ps

interface mbsp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface mbsp_msg_if;
	logic       valid;
	logic       ready;
	logic [3:0] msg_kind;
	logic [3:0] channel;
	logic [6:0] first_data;
	logic [6:0] second_data;
	logic [6:0] sysex_byte;
	logic       last;

	modport source (output valid, output msg_kind, output channel, output first_data,
		output second_data, output sysex_byte, output last, input ready);
	modport sink (input valid, input msg_kind, input channel, input first_data,
		input second_data, input sysex_byte, input last, output ready);
endinterface

FILE: hdl/mbsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mbsp_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/mbsp_ctrl.sv
// Controller: request acceptance and the sysex read-out sequence.
`timescale 1ns / 1ps

module mbsp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rx_valid,
	output logic                  rx_ready,
	input  mbsp_pkg::mbsp_stat_t  stat,
	output mbsp_pkg::mbsp_cmd_t   cmd
);
	import mbsp_pkg::*;

	mbsp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		rx_ready = 1'b0;
		case (state_q)
			CS_RUN: begin
				rx_ready = stat.out_free;
				cmd.take = rx_valid && stat.out_free;
				if (cmd.take && stat.dump_req) begin
					state_d = CS_DUMP_RD;
				end
			end
			CS_DUMP_RD: begin
				state_d = CS_DUMP_WR;
			end
			CS_DUMP_WR: begin
				if (stat.out_free) begin
					cmd.load_sx = 1'b1;
					if (stat.dump_last) begin
						cmd.finish = 1'b1;
						state_d    = CS_RUN;
					end else begin
						cmd.step = 1'b1;
						state_d  = CS_DUMP_RD;
					end
				end
			end
			default: begin
				state_d = CS_RUN;
			end
		endcase
	end

endmodule

FILE: hdl/mbsp_dp.sv
// Datapath: message decode, data byte collection, sysex store and output register.
`timescale 1ns / 1ps

module mbsp_dp #(
	parameter int SYSEX_DEPTH = mbsp_pkg::SYSEX_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           rx_byte,
	input  mbsp_pkg::mbsp_cmd_t  cmd,
	output mbsp_pkg::mbsp_stat_t stat,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [3:0]           msg_kind,
	output logic [3:0]           channel,
	output logic [6:0]           first_data,
	output logic [6:0]           second_data,
	output logic [6:0]           sysex_byte,
	output logic                 last
);
	import mbsp_pkg::*;

	localparam int AW = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;
	localparam int CW = $clog2(SYSEX_DEPTH + 1);

	mbsp_mode_t  mode_q;
	logic        taken_q;
	logic        need_two_q;
	logic [3:0]  kind_q;
	logic [3:0]  chan_q;
	logic [6:0]  held_first_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] rd_idx_q;
	logic        out_valid_q;

	logic        ram_we;
	logic [6:0]  ram_rdata;

	logic        emit;
	logic [3:0]  e_kind;
	logic [3:0]  e_chan;
	logic [6:0]  e_first;
	logic [6:0]  e_second;
	logic        is_data;

	assign is_data = !rx_byte[7];
	assign ram_we  = cmd.take && is_data && (mode_q == MODE_SYSEX)
		&& (count_q < CW'(SYSEX_DEPTH));

	mbsp_ram #(
		.WIDTH(7),
		.DEPTH(SYSEX_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(count_q)),
		.wdata(rx_byte[6:0]),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	// result caused by the byte being taken, if any
	always_comb begin
		emit     = 1'b0;
		e_kind   = kind_q;
		e_chan   = chan_q;
		e_first  = 7'd0;
		e_second = 7'd0;
		if (is_data) begin
			if (mode_q == MODE_MSG) begin
				if (!taken_q) begin
					emit    = !need_two_q;
					e_first = rx_byte[6:0];
				end else begin
					emit     = 1'b1;
					e_first  = held_first_q;
					e_second = rx_byte[6:0];
				end
			end
		end else begin
			e_chan = rx_byte[3:0];
			case (rx_byte)
				ST_START: begin
					emit   = 1'b1;
					e_kind = KIND_START;
				end
				ST_CONT: begin
					emit   = 1'b1;
					e_kind = KIND_CONT;
				end
				ST_STOP: begin
					emit   = 1'b1;
					e_kind = KIND_STOP;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	// message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			taken_q <= 1'b0;
		end else if (cmd.take) begin
			if (!is_data) begin
				taken_q <= 1'b0;
				if (rx_byte[7:4] != ST_SYSTEM) begin
					mode_q <= MODE_MSG;
				end else begin
					case (rx_byte)
						ST_SYSEX:   mode_q <= MODE_SYSEX;
						ST_QFRAME:  mode_q <= MODE_MSG;
						ST_SONGPOS: mode_q <= MODE_MSG;
						default:    mode_q <= MODE_IDLE;
					endcase
				end
			end else if (mode_q == MODE_MSG) begin
				if (taken_q || !need_two_q) begin
					mode_q <= MODE_IDLE;
				end else begin
					taken_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			if (!is_data) begin
				held_first_q <= 7'd0;
				chan_q       <= rx_byte[3:0];
				if (rx_byte[7:4] != ST_SYSTEM) begin
					kind_q     <= {1'b0, rx_byte[6:4]};
					need_two_q <= !((rx_byte[6:4] == CH_PROG)
						|| (rx_byte[6:4] == CH_CHANPRESS));
				end else if (rx_byte == ST_QFRAME) begin
					kind_q     <= KIND_QFRAME;
					need_two_q <= 1'b0;
				end else begin
					kind_q     <= KIND_SONGPOS;
					need_two_q <= 1'b1;
				end
			end else if (mode_q == MODE_MSG && !taken_q) begin
				held_first_q <= rx_byte[6:0];
			end
		end
	end

	// sysex fill count and read-out index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.finish) begin
				count_q  <= '0;
				rd_idx_q <= '0;
			end else begin
				if (cmd.take && !is_data && rx_byte == ST_SYSEX) begin
					count_q <= '0;
				end else if (ram_we) begin
					count_q <= count_q + CW'(1);
				end
				if (cmd.step) begin
					rd_idx_q <= rd_idx_q + AW'(1);
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.take && emit) || cmd.load_sx) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sx) begin
			msg_kind    <= KIND_SYSEX;
			channel     <= 4'd0;
			first_data  <= 7'd0;
			second_data <= 7'd0;
			sysex_byte  <= ram_rdata;
			last        <= stat.dump_last;
		end else if (cmd.take && emit) begin
			msg_kind    <= e_kind;
			channel     <= e_chan;
			first_data  <= e_first;
			second_data <= e_second;
			sysex_byte  <= 7'd0;
			last        <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.dump_req  = !is_data && (rx_byte == ST_EOX) && (count_q != '0);
	assign stat.dump_last = ((CW'(rd_idx_q) + CW'(1)) == count_q);

endmodule

FILE: hdl/midi_byte_stream_parser.sv
// Top level of the MIDI byte stream parser.
//
//  channel  dir  payload                                               
//  rx       in   rx_byte                                               
//  msg      out  msg_kind, channel, first_data, second_data,
//                sysex_byte, last
//
// A byte is taken whenever the output register is free or being emptied;
// messages appear in the output register the next cycle. On 0xF7 the
// sysex store is read out one result at a time (RAM read, then output load
// once the register is free), input held off until the run ends.
// Reset is asynchronous, active low; the store needs no clearing pass.
// A stalled msg channel holds off rx while a result waits in the output register.
`timescale 1ns / 1ps

module midi_byte_stream_parser #(
	parameter int SYSEX_DEPTH = mbsp_pkg::SYSEX_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	mbsp_rx_if.sink    rx,
	mbsp_msg_if.source msg
);
	import mbsp_pkg::*;

	mbsp_cmd_t  cmd;
	mbsp_stat_t stat;

	mbsp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_valid(rx.valid),
		.rx_ready(rx.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	mbsp_dp #(
		.SYSEX_DEPTH(SYSEX_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (rx.rx_byte),
		.cmd        (cmd),
		.stat       (stat),
		.out_ready  (msg.ready),
		.out_valid  (msg.valid),
		.msg_kind   (msg.msg_kind),
		.channel    (msg.channel),
		.first_data (msg.first_data),
		.second_data(msg.second_data),
		.sysex_byte (msg.sysex_byte),
		.last       (msg.last)
	);

endmodule
